FILE: rtl/text_console_writer_core_defines.svh
// Assertion macros for the text console writer core.
// Included by the top level; no other dependencies.
`ifndef TEXT_CONSOLE_WRITER_CORE_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_CORE_DEFINES_SVH

// Clocked assertion that is switched off while reset is high.
`define TCW_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// Same check on the core's own clock and reset.
`define TCW_CHECK(label, prop, msg) \
   `TCW_ASSERT(label, clock, reset, prop, msg)

`endif

FILE: rtl/tcw_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the text console writer core.
// No dependencies; every other source file but the defines header imports this package.
package tcw_pkg;

   localparam int COLS       = 80;
   localparam int ROWS       = 25;
   localparam int CELLS      = COLS * ROWS;
   localparam int SCROLL_LEN = (ROWS - 1) * COLS;
   localparam int ADDR_W     = $clog2(CELLS);

   localparam int FUNC_W    = 2;
   localparam int CHAR_W    = 8;
   localparam int ATTR_W    = 8;
   localparam int CELL_W    = CHAR_W + ATTR_W;
   localparam int COL_W     = 7;
   localparam int ROW_W     = 5;
   localparam int OFFSET_W  = 11;
   localparam int POS_W     = 12;
   localparam int CSR_IDX_W = 1;

   localparam logic [CHAR_W-1:0] CH_LF      = 8'd10;
   localparam logic [CHAR_W-1:0] CH_CR      = 8'd13;
   localparam logic [CHAR_W-1:0] CH_SPACE   = 8'd32;
   localparam logic [ATTR_W-1:0] RESET_ATTR = 8'd7;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_PUT        = 2'd0,
      FUNC_BACKSPACE  = 2'd1,
      FUNC_SET_CURSOR = 2'd2,
      FUNC_READ_CELL  = 2'd3
   } func_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TEXT_COLOR = 1'b0,
      CSR_BLANK_ATTR = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic [CHAR_W-1:0] char_code;
      logic [COL_W-1:0]  target_col;
      logic [ROW_W-1:0]  target_row;
   } req_word_type;

   typedef struct packed {
      logic [COL_W-1:0]    cursor_col;
      logic [ROW_W-1:0]    cursor_row;
      logic [OFFSET_W-1:0] cursor_offset;
      logic                line_start_erased;
      logic                applied;
      logic [CHAR_W-1:0]   cell_char;
      logic [ATTR_W-1:0]   cell_attr;
   } rsp_word_type;

   typedef struct packed {
      logic capture;
      logic clear_step;
      logic scroll_step;
      logic fill_step;
      logic apply;
      logic load_rsp;
   } ctl_cmd_type;

   typedef struct packed {
      logic clear_end;
      logic scroll_end;
      logic fill_end;
      logic needs_scroll;
      logic rsp_free;
   } ctl_status_type;

endpackage

FILE: rtl/tcw_channels.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for requests, responses and register writes.
// Depends on tcw_pkg for the field widths.
interface tcw_req_if import tcw_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [FUNC_W-1:0]   func;
   logic [CHAR_W-1:0]   char_code;
   logic [COL_W-1:0]    target_col;
   logic [ROW_W-1:0]    target_row;

   modport source (output valid, func, char_code, target_col, target_row, input ready);
   modport sink   (input valid, func, char_code, target_col, target_row, output ready);
endinterface

interface tcw_rsp_if import tcw_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [COL_W-1:0]    cursor_col;
   logic [ROW_W-1:0]    cursor_row;
   logic [OFFSET_W-1:0] cursor_offset;
   logic                line_start_erased;
   logic                applied;
   logic [CHAR_W-1:0]   cell_char;
   logic [ATTR_W-1:0]   cell_attr;

   modport source (output valid, cursor_col, cursor_row, cursor_offset, line_start_erased,
                   applied, cell_char, cell_attr, input ready);
   modport sink   (input valid, cursor_col, cursor_row, cursor_offset, line_start_erased,
                   applied, cell_char, cell_attr, output ready);
endinterface

interface tcw_csr_if import tcw_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [ATTR_W-1:0]    data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/tcw_ctrl.sv
`timescale 1ns / 1ps
// Sequencing state machine of the text console writer core.
// Depends on tcw_pkg; drives the datapath through command and status structs.
module tcw_ctrl import tcw_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   output ctl_cmd_type    cmd,
   input  ctl_status_type status
);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC,
      ST_SCROLL,
      ST_FILL,
      ST_APPLY,
      ST_RESP
   } state_type;

   state_type state_ff;
   logic      ready_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         ready_ff <= 1'b0;
      end else begin
         case (state_ff)
            ST_CLEAR: begin
               if (status.clear_end) begin
                  state_ff <= ST_IDLE;
                  ready_ff <= 1'b1;
               end
            end
            ST_IDLE: begin
               if (req_valid) begin
                  state_ff <= ST_EXEC;
                  ready_ff <= 1'b0;
               end
            end
            ST_EXEC: begin
               state_ff <= status.needs_scroll ? ST_SCROLL : ST_APPLY;
            end
            ST_SCROLL: begin
               if (status.scroll_end) begin
                  state_ff <= ST_FILL;
               end
            end
            ST_FILL: begin
               if (status.fill_end) begin
                  state_ff <= ST_APPLY;
               end
            end
            ST_APPLY: begin
               state_ff <= ST_RESP;
            end
            ST_RESP: begin
               if (status.rsp_free) begin
                  state_ff <= ST_IDLE;
                  ready_ff <= 1'b1;
               end
            end
            default: begin
               state_ff <= ST_CLEAR;
               ready_ff <= 1'b0;
            end
         endcase
      end
   end

   always_comb begin
      cmd = '0;
      case (state_ff)
         ST_CLEAR:  cmd.clear_step  = 1'b1;
         ST_IDLE:   cmd.capture     = req_valid;
         ST_SCROLL: cmd.scroll_step = 1'b1;
         ST_FILL:   cmd.fill_step   = 1'b1;
         ST_APPLY:  cmd.apply       = 1'b1;
         ST_RESP:   cmd.load_rsp    = status.rsp_free;
         default:   cmd = '0;
      endcase
   end

   assign req_ready = ready_ff;

endmodule

FILE: rtl/tcw_datapath.sv
`timescale 1ns / 1ps
// Cursor registers, attribute registers, screen cell memory and response register.
// Depends on tcw_pkg; sequenced by tcw_ctrl.
module tcw_datapath import tcw_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  ctl_cmd_type          cmd,
   output ctl_status_type       status,
   input  req_word_type         req_word,
   input  logic                 csr_valid,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [ATTR_W-1:0]    csr_data,
   input  logic                 rsp_ready,
   output logic                 rsp_valid,
   output rsp_word_type         rsp_word
);

   function automatic logic [POS_W-1:0] cell_pos(input logic [ROW_W-1:0] row,
                                                 input logic [COL_W-1:0] col);
      return POS_W'(row) * POS_W'(COLS) + POS_W'(col);
   endfunction

   req_word_type      item_ff;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [ROW_W-1:0]  line_ff, line_in;
   logic [ROW_W-1:0]  mark_ff, mark_in;
   logic [ATTR_W-1:0] text_color_ff;
   logic [ATTR_W-1:0] blank_attr_ff;
   logic              erased_ff, erased_in;
   logic              applied_ff, applied_in;
   logic              read_hit_ff, read_hit_in;
   logic [ADDR_W-1:0] sweep_ff;
   logic              rsp_valid_ff;
   rsp_word_type      rsp_word_ff, rsp_word_in;

   logic [CELL_W-1:0] screen_ff [CELLS];
   logic [CELL_W-1:0] rd_data_ff;

   logic              is_newline, at_last_row, at_last_col, in_range;
   logic [ROW_W-1:0]  next_line;
   logic [COL_W-1:0]  put_col;
   logic              ap_wr_en, ap_rd_en;
   logic [ADDR_W-1:0] ap_wr_addr, ap_rd_addr;
   logic [CELL_W-1:0] ap_wr_data;
   logic              wr_en, rd_en;
   logic [ADDR_W-1:0] wr_addr, rd_addr;
   logic [CELL_W-1:0] wr_data;
   logic              sweep_wrap;

   assign is_newline  = (item_ff.char_code == CH_LF) || (item_ff.char_code == CH_CR);
   assign at_last_row = line_ff >= ROW_W'(ROWS - 1);
   assign at_last_col = col_ff >= COL_W'(COLS - 1);
   assign in_range    = (item_ff.target_col < COL_W'(COLS)) &&
                        (item_ff.target_row < ROW_W'(ROWS));
   assign next_line   = at_last_row ? ROW_W'(ROWS - 1) : line_ff + ROW_W'(1);

   always_comb begin
      col_in      = col_ff;
      line_in     = line_ff;
      mark_in     = mark_ff;
      erased_in   = 1'b0;
      applied_in  = 1'b1;
      read_hit_in = 1'b0;
      put_col     = col_ff;
      ap_wr_en    = 1'b0;
      ap_wr_addr  = '0;
      ap_wr_data  = {text_color_ff, item_ff.char_code};
      ap_rd_en    = 1'b0;
      ap_rd_addr  = ADDR_W'(cell_pos(item_ff.target_row, item_ff.target_col));
      case (item_ff.func)
         FUNC_PUT: begin
            if (is_newline) begin
               line_in = next_line;
               col_in  = '0;
            end else begin
               if (at_last_col) begin
                  mark_in = next_line;
                  line_in = next_line;
                  put_col = '0;
               end
               ap_wr_en   = 1'b1;
               ap_wr_addr = ADDR_W'(cell_pos(line_in, put_col));
               col_in     = put_col + COL_W'(1);
            end
         end
         FUNC_BACKSPACE: begin
            if (col_ff == '0 && line_ff == '0) begin
               applied_in = 1'b0;
            end else begin
               if (col_ff == '0) begin
                  col_in  = COL_W'(COLS - 1);
                  line_in = line_ff - ROW_W'(1);
               end else begin
                  col_in = col_ff - COL_W'(1);
               end
               erased_in  = (col_in == '0) && (line_in == mark_ff);
               ap_wr_en   = 1'b1;
               ap_wr_addr = ADDR_W'(cell_pos(line_in, col_in));
               ap_wr_data = {blank_attr_ff, CH_SPACE};
            end
         end
         FUNC_SET_CURSOR: begin
            if (in_range) begin
               col_in  = item_ff.target_col;
               line_in = item_ff.target_row;
            end else begin
               applied_in = 1'b0;
            end
         end
         FUNC_READ_CELL: begin
            if (in_range) begin
               ap_rd_en    = 1'b1;
               read_hit_in = 1'b1;
            end else begin
               applied_in = 1'b0;
            end
         end
         default: begin
            applied_in = 1'b0;
         end
      endcase
   end

   // The scroll copy reads one row ahead and writes the previous read in the next cycle.
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = sweep_ff;
      wr_data = {RESET_ATTR, CH_SPACE};
      rd_en   = 1'b0;
      rd_addr = sweep_ff + ADDR_W'(COLS);
      if (cmd.clear_step) begin
         wr_en = 1'b1;
      end else if (cmd.scroll_step) begin
         wr_en   = sweep_ff != '0;
         wr_addr = sweep_ff - ADDR_W'(1);
         wr_data = {blank_attr_ff, rd_data_ff[CHAR_W-1:0]};
         rd_en   = sweep_ff < ADDR_W'(SCROLL_LEN);
      end else if (cmd.fill_step) begin
         wr_en   = 1'b1;
         wr_addr = sweep_ff + ADDR_W'(SCROLL_LEN);
         wr_data = {blank_attr_ff, CH_SPACE};
      end else if (cmd.apply) begin
         wr_en   = ap_wr_en;
         wr_addr = ap_wr_addr;
         wr_data = ap_wr_data;
         rd_en   = ap_rd_en;
         rd_addr = ap_rd_addr;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         screen_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= screen_ff[rd_addr];
      end
   end

   assign status.clear_end    = sweep_ff == ADDR_W'(CELLS - 1);
   assign status.scroll_end   = sweep_ff == ADDR_W'(SCROLL_LEN);
   assign status.fill_end     = sweep_ff == ADDR_W'(COLS - 1);
   assign status.needs_scroll = (item_ff.func == FUNC_PUT) && (is_newline || at_last_col) &&
                                at_last_row;
   assign status.rsp_free     = !rsp_valid_ff || rsp_ready;

   assign sweep_wrap = (cmd.clear_step && status.clear_end) ||
                       (cmd.scroll_step && status.scroll_end) ||
                       (cmd.fill_step && status.fill_end);

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_ff <= '0;
      end else if (sweep_wrap) begin
         sweep_ff <= '0;
      end else if (cmd.clear_step || cmd.scroll_step || cmd.fill_step) begin
         sweep_ff <= sweep_ff + ADDR_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         text_color_ff <= RESET_ATTR;
         blank_attr_ff <= RESET_ATTR;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_TEXT_COLOR: text_color_ff <= csr_data;
            CSR_BLANK_ATTR: blank_attr_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         line_ff <= '0;
         mark_ff <= '0;
      end else if (cmd.apply) begin
         col_ff  <= col_in;
         line_ff <= line_in;
         mark_ff <= mark_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         item_ff <= req_word;
      end
      if (cmd.apply) begin
         erased_ff   <= erased_in;
         applied_ff  <= applied_in;
         read_hit_ff <= read_hit_in;
      end
   end

   always_comb begin
      rsp_word_in.cursor_col        = col_ff;
      rsp_word_in.cursor_row        = line_ff;
      rsp_word_in.cursor_offset     = OFFSET_W'(cell_pos(line_ff, col_ff));
      rsp_word_in.line_start_erased = erased_ff;
      rsp_word_in.applied           = applied_ff;
      rsp_word_in.cell_char         = read_hit_ff ? rd_data_ff[CHAR_W-1:0] : '0;
      rsp_word_in.cell_attr         = read_hit_ff ? rd_data_ff[CELL_W-1:CHAR_W] : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

FILE: rtl/text_console_writer_core.sv
`timescale 1ns / 1ps
// Top level of the text console writer core: controller, datapath and channel glue.
// Depends on tcw_pkg, the channel interfaces, tcw_ctrl, tcw_datapath and the defines header.
//
// The request channel carries one command word: put a character, backspace,
// set the cursor or read one cell of the 80 x 25 screen. Every request word
// gives exactly one response word with the cursor after the command, its
// linear offset, the line-start erase flag, the applied flag and the read cell.
// The register channel sets the text color and the blank attribute; it is
// always ready and should only be used while no request is outstanding.
// After acceptance a request passes through the execute, apply and response states;
// the response register is loaded once it is free, and the next request is accepted
// after that. A newline or a wrap on the last row first scrolls the screen memory
// one cell per cycle: a copy sweep moves the rows up and a fill sweep blanks the last row.
// After reset the memory is cleared to spaces with attribute 7, one cell per
// cycle, so requests are held off until all ROWS*COLS = 2000 cells are cleared.
// A response waits in its output register while the receiver stalls; the
// next request may still be accepted, but its response is held back until
// that register has been handed over.
`include "text_console_writer_core_defines.svh"
module text_console_writer_core import tcw_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   tcw_req_if.sink    req_bus,
   tcw_rsp_if.source  rsp_bus,
   tcw_csr_if.sink    csr_bus
);

   ctl_cmd_type    ctl_cmd;
   ctl_status_type ctl_status;
   req_word_type   req_word;
   rsp_word_type   rsp_word;
   logic           rsp_valid;
   logic           req_ready;

   assign req_word.func       = req_bus.func;
   assign req_word.char_code  = req_bus.char_code;
   assign req_word.target_col = req_bus.target_col;
   assign req_word.target_row = req_bus.target_row;
   assign req_bus.ready       = req_ready;

   assign csr_bus.ready = 1'b1;

   tcw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_ready),
      .cmd       (ctl_cmd),
      .status    (ctl_status)
   );

   tcw_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (ctl_cmd),
      .status    (ctl_status),
      .req_word  (req_word),
      .csr_valid (csr_bus.valid),
      .csr_index (csr_bus.index),
      .csr_data  (csr_bus.data),
      .rsp_ready (rsp_bus.ready),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word)
   );

   assign rsp_bus.valid             = rsp_valid;
   assign rsp_bus.cursor_col        = rsp_word.cursor_col;
   assign rsp_bus.cursor_row        = rsp_word.cursor_row;
   assign rsp_bus.cursor_offset     = rsp_word.cursor_offset;
   assign rsp_bus.line_start_erased = rsp_word.line_start_erased;
   assign rsp_bus.applied           = rsp_word.applied;
   assign rsp_bus.cell_char         = rsp_word.cell_char;
   assign rsp_bus.cell_attr         = rsp_word.cell_attr;

   `TCW_CHECK(a_load_into_free_slot, ctl_cmd.load_rsp |-> (!rsp_bus.valid || rsp_bus.ready), "response loaded over a pending word")
   `TCW_CHECK(a_no_accept_in_sweep, req_bus.ready |-> !(ctl_cmd.clear_step || ctl_cmd.scroll_step || ctl_cmd.fill_step), "request ready during a memory sweep")
   `TCW_CHECK(a_cursor_on_screen, rsp_bus.valid |-> (rsp_bus.cursor_col < COL_W'(COLS)) && (rsp_bus.cursor_row < ROW_W'(ROWS)), "cursor outside the screen")
   `TCW_CHECK(a_rsp_from_load, $rose(rsp_bus.valid) |-> $past(ctl_cmd.load_rsp), "response valid without a load")

endmodule

FILE: tb/tcw_screen_checker.sv
`timescale 1ns / 1ps
// Screen checker for the text console writer core: keeps its own copy of the screen,
// cursor and attributes, predicts each response word and compares it with the one seen.
// Depends on tcw_pkg and the channel interfaces in tcw_channels.sv.
module tcw_screen_checker import tcw_pkg::*; (
   input  logic clock,
   input  logic reset,
   tcw_req_if   req_mon,
   tcw_rsp_if   rsp_mon,
   tcw_csr_if   csr_mon,
   output int   fail_count,
   output int   pending_words
);

   logic [ATTR_W-1:0] text_attr;
   logic [ATTR_W-1:0] blank_attr;
   logic [COL_W-1:0]  cur_col;
   logic [ROW_W-1:0]  cur_row;
   logic [ROW_W-1:0]  wrap_row;
   logic [CELL_W-1:0] screen [CELLS];
   rsp_word_type      expected_q [$];

   initial begin
      fail_count = 0;
      pending_words = 0;
   end

   function automatic int cell_index(logic [ROW_W-1:0] row, logic [COL_W-1:0] col);
      return int'(row) * COLS + int'(col);
   endfunction

   function automatic void reset_screen();
      text_attr = RESET_ATTR;
      blank_attr = RESET_ATTR;
      cur_col = '0;
      cur_row = '0;
      wrap_row = '0;
      for (int i = 0; i < CELLS; i++) begin
         screen[i] = {RESET_ATTR, CH_SPACE};
      end
   endfunction

   // Rows move up keeping their characters; every attribute becomes the blank one.
   function automatic void scroll_screen();
      for (int i = 0; i < SCROLL_LEN; i++) begin
         screen[i] = {blank_attr, screen[i + COLS][CHAR_W-1:0]};
      end
      for (int i = SCROLL_LEN; i < CELLS; i++) begin
         screen[i] = {blank_attr, CH_SPACE};
      end
   endfunction

   function automatic void next_line();
      if (cur_row >= ROWS - 1) begin
         scroll_screen();
         cur_row = ROW_W'(ROWS - 1);
      end else begin
         cur_row = cur_row + 1'b1;
      end
      cur_col = '0;
   endfunction

   function automatic void print_char(logic [CHAR_W-1:0] ch);
      if (ch == CH_LF || ch == CH_CR) begin
         next_line();
      end else begin
         if (cur_col >= COLS - 1) begin
            wrap_row = (int'(cur_row) + 1 >= ROWS) ? cur_row : cur_row + 1'b1;
            next_line();
         end
         screen[cell_index(cur_row, cur_col)] = {text_attr, ch};
         cur_col = (cur_col >= COLS - 1) ? '0 : cur_col + 1'b1;
      end
   endfunction

   function automatic rsp_word_type predict_word(req_word_type w);
      rsp_word_type r;
      r = '0;
      r.applied = 1'b1;
      case (func_type'(w.func))
         FUNC_PUT: begin
            print_char(w.char_code);
         end
         FUNC_BACKSPACE: begin
            if (cur_col == 0 && cur_row == 0) begin
               r.applied = 1'b0;
            end else begin
               if (cur_col == 0) begin
                  cur_col = COL_W'(COLS - 1);
                  cur_row = cur_row - 1'b1;
               end else begin
                  cur_col = cur_col - 1'b1;
               end
               r.line_start_erased = (cur_col == 0 && cur_row == wrap_row);
               screen[cell_index(cur_row, cur_col)] = {blank_attr, CH_SPACE};
            end
         end
         FUNC_SET_CURSOR: begin
            if (w.target_col >= COLS || w.target_row >= ROWS) begin
               r.applied = 1'b0;
            end else begin
               cur_col = w.target_col;
               cur_row = w.target_row;
            end
         end
         FUNC_READ_CELL: begin
            if (w.target_col >= COLS || w.target_row >= ROWS) begin
               r.applied = 1'b0;
            end else begin
               {r.cell_attr, r.cell_char} = screen[cell_index(w.target_row, w.target_col)];
            end
         end
         default: ;
      endcase
      r.cursor_col = cur_col;
      r.cursor_row = cur_row;
      r.cursor_offset = OFFSET_W'(cell_index(cur_row, cur_col));
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
      fail_count++;
      $display("%0t ns: %s mismatch, got %0h expected %0h", $realtime, what, got, want);
   endtask

   task automatic check_field(string what, logic [15:0] got, logic [15:0] want);
      if (got !== want) begin
         report_mismatch(what, got, want);
      end
   endtask

   always @(posedge clock) begin
      rsp_word_type want;
      req_word_type req;
      if (reset) begin
         reset_screen();
         expected_q.delete();
      end else begin
         if (csr_mon.valid && csr_mon.ready) begin
            case (csr_index_type'(csr_mon.index))
               CSR_TEXT_COLOR: text_attr = csr_mon.data;
               CSR_BLANK_ATTR: blank_attr = csr_mon.data;
               default: ;
            endcase
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_q.size() == 0) begin
               report_mismatch("unrequested word, offset", rsp_mon.cursor_offset, '0);
            end else begin
               want = expected_q.pop_front();
               check_field("cursor_col", rsp_mon.cursor_col, want.cursor_col);
               check_field("cursor_row", rsp_mon.cursor_row, want.cursor_row);
               check_field("cursor_offset", rsp_mon.cursor_offset, want.cursor_offset);
               check_field("line_start_erased", rsp_mon.line_start_erased,
                           want.line_start_erased);
               check_field("applied", rsp_mon.applied, want.applied);
               check_field("cell_char", rsp_mon.cell_char, want.cell_char);
               check_field("cell_attr", rsp_mon.cell_attr, want.cell_attr);
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            req = {req_mon.func, req_mon.char_code, req_mon.target_col, req_mon.target_row};
            expected_q.push_back(predict_word(req));
         end
      end
      pending_words <= expected_q.size();
   end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// Top of the text console writer testbench: clock, reset, stimulus and the verdict.
// Depends on tcw_pkg, the channel interfaces, the core and tcw_screen_checker.
module tb_top;
   import tcw_pkg::*;

   localparam int CYCLE_LIMIT = 10_000_000;
   localparam int DIRECTED_WORDS = 25;
   localparam int PHASE_WORDS = 384;

   logic clock;
   logic reset;
   int   tx_idle_pct = 19;
   int   rx_idle_pct = 63;
   int   words_sent = 0;
   int   cycle_count = 0;
   int   fail_count;
   int   pending_words;

   tcw_req_if req_if ();
   tcw_rsp_if rsp_if ();
   tcw_csr_if csr_if ();

   text_console_writer_core dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_if),
      .rsp_bus (rsp_if),
      .csr_bus (csr_if)
   );

   tcw_screen_checker screen_check (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_if),
      .rsp_mon       (rsp_if),
      .csr_mon       (csr_if),
      .fail_count    (fail_count),
      .pending_words (pending_words)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("text_console_writer_core verification failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_if.ready <= !reset && ($urandom_range(99) >= rx_idle_pct);
   end

   task automatic send_word(func_type f, logic [CHAR_W-1:0] ch, logic [COL_W-1:0] col,
                            logic [ROW_W-1:0] row);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.func <= f;
      req_if.char_code <= ch;
      req_if.target_col <= col;
      req_if.target_row <= row;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      words_sent++;
   endtask

   task automatic put_byte(logic [CHAR_W-1:0] ch);
      send_word(FUNC_PUT, ch, COL_W'($urandom), ROW_W'($urandom));
   endtask

   task automatic backspace_once();
      send_word(FUNC_BACKSPACE, CHAR_W'($urandom), COL_W'($urandom), ROW_W'($urandom));
   endtask

   task automatic move_cursor(logic [COL_W-1:0] col, logic [ROW_W-1:0] row);
      send_word(FUNC_SET_CURSOR, CHAR_W'($urandom), col, row);
   endtask

   task automatic read_at(logic [COL_W-1:0] col, logic [ROW_W-1:0] row);
      send_word(FUNC_READ_CELL, CHAR_W'($urandom), col, row);
   endtask

   task automatic wait_idle();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (pending_words != 0);
   endtask

   task automatic write_reg(csr_index_type idx, logic [ATTR_W-1:0] value);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data <= value;
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
      csr_if.valid <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      int kind;
      int burst;
      int erase_count;
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.func = FUNC_PUT;
      req_if.char_code = '0;
      req_if.target_col = '0;
      req_if.target_row = '0;
      rsp_if.ready = 1'b0;
      csr_if.valid = 1'b0;
      csr_if.index = CSR_TEXT_COLOR;
      csr_if.data = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      write_reg(CSR_TEXT_COLOR, 8'hFF);
      write_reg(CSR_BLANK_ATTR, 8'h00);

      read_at(0, 0);
      read_at(COL_W'(127), ROW_W'(31));
      backspace_once();
      move_cursor(COL_W'(COLS), 0);
      move_cursor(0, ROW_W'(ROWS));
      move_cursor(COL_W'(127), ROW_W'(31));
      put_byte(8'h00);
      put_byte(8'hFF);
      put_byte(CH_LF);
      put_byte(CH_CR);
      // A character at the last column wraps; backspacing onto the marked row flags it.
      move_cursor(COL_W'(COLS - 1), 3);
      put_byte("A");
      backspace_once();
      backspace_once();
      // Wrapping on the last row scrolls, and so does a newline there.
      move_cursor(COL_W'(COLS - 1), ROW_W'(ROWS - 1));
      put_byte("B");
      read_at(0, ROW_W'(ROWS - 2));
      read_at(0, ROW_W'(ROWS - 1));
      move_cursor(5, ROW_W'(ROWS - 1));
      put_byte(CH_LF);
      read_at(0, ROW_W'(ROWS - 3));
      move_cursor(0, 2);
      backspace_once();
      read_at(COL_W'(COLS - 1), ROW_W'(ROWS - 1));
      read_at(COL_W'(COLS), 0);

      for (int phase = 0; phase < 3; phase++) begin
         wait_idle();
         case (phase)
            0: begin
               write_reg(CSR_TEXT_COLOR, ATTR_W'($urandom));
               write_reg(CSR_BLANK_ATTR, ATTR_W'($urandom));
            end
            1: begin
               tx_idle_pct <= 63;
               rx_idle_pct <= 19;
               write_reg(CSR_TEXT_COLOR, 8'h00);
               write_reg(CSR_BLANK_ATTR, 8'hFF);
            end
            default: begin
               tx_idle_pct <= 0;
               rx_idle_pct <= 0;
               write_reg(CSR_TEXT_COLOR, ATTR_W'($urandom));
               write_reg(CSR_BLANK_ATTR, RESET_ATTR);
            end
         endcase
         while (words_sent < DIRECTED_WORDS + (phase + 1) * PHASE_WORDS) begin
            kind = $urandom_range(99);
            if (kind < 30) begin
               // Type near a row end, often across it, then erase back, possibly over the wrap.
               move_cursor(COL_W'(COLS - 1 - $urandom_range(3)),
                           ROW_W'($urandom_range(ROWS - 1)));
               burst = $urandom_range(6, 1);
               for (int i = 0; i < burst; i++) begin
                  put_byte(($urandom_range(15) == 0) ? CHAR_W'($urandom)
                                                     : CHAR_W'($urandom_range(126, 32)));
               end
               erase_count = $urandom_range(burst + 2);
               for (int i = 0; i < erase_count; i++) begin
                  backspace_once();
               end
            end else if (kind < 50) begin
               burst = $urandom_range(4, 1);
               for (int i = 0; i < burst; i++) begin
                  read_at(COL_W'($urandom_range(COLS - 1)), ROW_W'($urandom_range(ROWS - 1)));
               end
            end else if (kind < 53) begin
               move_cursor(COL_W'($urandom_range(COLS - 1)), ROW_W'(ROWS - 1));
               put_byte($urandom_range(1) ? CH_LF : CH_CR);
            end else if (kind < 85) begin
               burst = $urandom_range(12, 1);
               for (int i = 0; i < burst; i++) begin
                  put_byte(($urandom_range(9) == 0) ? CHAR_W'($urandom)
                                                    : CHAR_W'($urandom_range(126, 32)));
               end
            end else begin
               send_word(func_type'($urandom_range(3)), CHAR_W'($urandom), COL_W'($urandom),
                         ROW_W'($urandom));
            end
            if ($urandom_range(99) < 2) begin
               wait_idle();
            end
         end
      end

      wait_idle();
      repeat (8) @(posedge clock);
      @(negedge clock);
      if (fail_count == 0) begin
         $display("text_console_writer_core verification clean");
      end else begin
         $display("text_console_writer_core verification failed");
      end
      $finish;
   end

endmodule

FILE: files.f
+incdir+rtl
rtl/tcw_pkg.sv
rtl/tcw_channels.sv
rtl/tcw_ctrl.sv
rtl/tcw_datapath.sv
rtl/text_console_writer_core.sv
tb/tcw_screen_checker.sv
tb/tb_top.sv
